// File: rtl/particle_pool_update_defines.svh
// ----------------------------------------------------------------------------
// particle_pool_update_defines: assertion macros of the particle pool
// Concurrent assertion wrappers used by the checker files.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_POOL_UPDATE_DEFINES_SVH
`define PARTICLE_POOL_UPDATE_DEFINES_SVH

// Concurrent assertion, quiet while reset is applied
`define PP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent assertion that also holds through reset
`define PP_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pp_pkg.sv
// ----------------------------------------------------------------------------
// pp_pkg: shared types and constants of the particle pool
// Word layouts, opcodes, register indexes, state codes and the velocity table.
// ----------------------------------------------------------------------------
package pp_pkg;

  // Opcodes of an input word
  typedef enum logic [1:0] {
    OP_SPAWN = 2'd0,
    OP_TICK  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SPAWN_LIFE  = 2'd0,
    REG_SPAWN_ALPHA = 2'd1,
    REG_FADE_RATE   = 2'd2,
    REG_VIS_RAD_SQ  = 2'd3
  } reg_idx_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_TICK,
    ST_READ,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic signed [23:0] center_z;
    logic [15:0]        delta_time;
    logic [6:0]         rand_x;
    logic [6:0]         rand_y;
    logic [6:0]         rand_z;
    logic [7:0]         read_slot;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         slot;
    logic               alive;
    logic               visible;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [16:0]        alpha;
    logic [8:0]         alive_count;
  } out_word_t;

  // One particle as held in the pool memory
  typedef struct packed {
    logic [19:0]        life;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [16:0] vel_x;
    logic signed [16:0] vel_y;
    logic signed [16:0] vel_z;
    logic [16:0]        alpha;
    logic               vis;
  } part_t;

  localparam int PART_W = $bits(part_t);

  // Velocity for a random code r: r/100 - 0.5, rounded, in Q.16
  typedef logic signed [16:0] vel_tab_t [128];

  function automatic vel_tab_t build_vel_tab();
    vel_tab_t t;
    for (int r = 0; r < 128; r++) begin
      t[r] = 17'((r * 65536 + 50) / 100 - 32768);
    end
    return t;
  endfunction

  localparam vel_tab_t VEL_TAB = build_vel_tab();

  // Clamp a 25-bit sum to the 24-bit position range
  function automatic logic signed [23:0] sat_pos(input logic signed [24:0] v);
    logic signed [23:0] r;
    if (v[24] != v[23]) begin
      r = v[24] ? 24'sh800000 : 24'sh7FFFFF;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/pp_intf.sv
// ----------------------------------------------------------------------------
// pp_intf: valid/ready channels of the particle pool
// One interface for the input words and one for the result words.
// ----------------------------------------------------------------------------
interface pp_in_if;
  logic             valid;
  logic             ready;
  pp_pkg::in_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface pp_out_if;
  logic              valid;
  logic              ready;
  pp_pkg::out_word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

// File: rtl/pp_ram.sv
// ----------------------------------------------------------------------------
// pp_ram: generic single-port-write, single-port-read RAM
// One write and one read each cycle; read data is registered.
// ----------------------------------------------------------------------------
module pp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/particle_pool_update.sv
// ----------------------------------------------------------------------------
// particle_pool_update: pool of particles with spawn, tick and read items
// Spawns into a dead slot (slot 0 if none), ages and moves all particles, reports one slot.
// ----------------------------------------------------------------------------
// All particle state lives in one memory of NUM_PARTICLES words. After reset a
// clearing pass writes every slot to zero, one slot a cycle, so the block takes
// no input word until the pass is done. One item is handled at a time. A tick
// streams every slot through a read-modify-write pipeline, one slot a cycle. A
// spawn scans the pool for a dead slot one slot a cycle from the last spawned
// slot. The result word is held in an output register, so the next item is
// taken while it waits.
module particle_pool_update #(
  parameter int NUM_PARTICLES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  pp_in_if.sink       in_w,
  pp_out_if.source    out_w,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
  localparam int CW = $clog2(NUM_PARTICLES + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(NUM_PARTICLES - 1);
  localparam logic [CW-1:0] POOL_CNT  = CW'(NUM_PARTICLES);

  // Configuration registers
  logic [19:0] spawn_life_r;
  logic [16:0] spawn_alpha_r;
  logic [19:0] fade_rate_r;
  logic [31:0] vis_rad_sq_r;

  // Control state
  pp_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]  addr_r, addr_nxt;
  logic [CW-1:0]  iss_r, iss_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [AW-1:0]  sstart_r, sstart_nxt;
  logic           issue;
  logic           out_valid_r;
  logic           out_load;

  // Item and result holding
  pp_pkg::in_word_t  item_r;
  logic [19:0]       loss_r;
  pp_pkg::out_word_t res_r, res_nxt;
  pp_pkg::out_word_t out_word_r;
  pp_pkg::out_word_t out_load_w;

  // Memory ports
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  pp_pkg::part_t   ram_wdata, ram_rdata;

  // Tick pipeline
  logic               v1_r, v2_r, v3_r, v4_r;
  logic [AW-1:0]      a1_r, a2_r, a3_r, a4_r;
  pp_pkg::part_t      w2_r, w3_r, w4_r;
  logic [19:0]        life2_r;
  logic signed [33:0] px2_r, py2_r, pz2_r;
  logic signed [24:0] dx3_r, dy3_r, dz3_r;
  logic               al3_r, ol3_r, al4_r, ol4_r;
  logic [48:0]        sqx4_r, sqy4_r, sqz4_r;

  // Spawn selection
  logic [AW-1:0]  sel_slot;
  logic           old_alive;
  logic           spawn_now;
  pp_pkg::part_t  spawn_word;

  logic cfg_wr;
  logic [35:0] loss_prod;

  pp_ram #(
    .WIDTH (pp_pkg::PART_W),
    .DEPTH (NUM_PARTICLES)
  ) u_pool (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spawn_life_r  <= 20'd655360;
      spawn_alpha_r <= 17'd65536;
      fade_rate_r   <= 20'd163840;
      vis_rad_sq_r  <= 32'd262144;
    end else if (cfg_wr) begin
      unique case (pp_pkg::reg_idx_t'(paddr[3:2]))
        pp_pkg::REG_SPAWN_LIFE:  spawn_life_r  <= pwdata[19:0];
        pp_pkg::REG_SPAWN_ALPHA: spawn_alpha_r <= pwdata[16:0];
        pp_pkg::REG_FADE_RATE:   fade_rate_r   <= pwdata[19:0];
        pp_pkg::REG_VIS_RAD_SQ:  vis_rad_sq_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (pp_pkg::reg_idx_t'(paddr[3:2]))
      pp_pkg::REG_SPAWN_LIFE:  prdata = {12'd0, spawn_life_r};
      pp_pkg::REG_SPAWN_ALPHA: prdata = {15'd0, spawn_alpha_r};
      pp_pkg::REG_FADE_RATE:   prdata = {12'd0, fade_rate_r};
      pp_pkg::REG_VIS_RAD_SQ:  prdata = vis_rad_sq_r;
      default:                 prdata = '0;
    endcase
  end

  // Alpha loss of one tick, taken once per item
  assign loss_prod = fade_rate_r * in_w.word.delta_time;

  // Stage 2 terms: new life and velocity times dt
  logic [19:0]        life_s1;
  logic signed [33:0] px_s1, py_s1, pz_s1;
  logic signed [16:0] dt_s;

  assign dt_s    = $signed({1'b0, item_r.delta_time});
  assign life_s1 = (ram_rdata.life > 20'(item_r.delta_time))
                   ? ram_rdata.life - 20'(item_r.delta_time) : 20'd0;
  assign px_s1   = ram_rdata.vel_x * dt_s;
  assign py_s1   = ram_rdata.vel_y * dt_s;
  assign pz_s1   = ram_rdata.vel_z * dt_s;

  // Stage 3 terms: move, fade, offset from the centre
  logic signed [23:0] nx_s2, ny_s2, nz_s2;
  logic [16:0]        alpha_s2;
  logic               alive_s2;
  pp_pkg::part_t      w_s2;

  always_comb begin
    nx_s2 = pp_pkg::sat_pos({w2_r.pos_x[23], w2_r.pos_x}
                            + {{7{px2_r[33]}}, px2_r[33:16]});
    ny_s2 = pp_pkg::sat_pos({w2_r.pos_y[23], w2_r.pos_y}
                            + {{7{py2_r[33]}}, py2_r[33:16]});
    nz_s2 = pp_pkg::sat_pos({w2_r.pos_z[23], w2_r.pos_z}
                            + {{7{pz2_r[33]}}, pz2_r[33:16]});
    alpha_s2 = ({3'd0, w2_r.alpha} > loss_r) ? w2_r.alpha - 17'(loss_r) : 17'd0;
    alive_s2 = (life2_r != 20'd0);
    w_s2      = w2_r;
    w_s2.life = life2_r;
    if (alive_s2) begin
      w_s2.pos_x = nx_s2;
      w_s2.pos_y = ny_s2;
      w_s2.pos_z = nz_s2;
      w_s2.alpha = alpha_s2;
    end
  end

  // Stage 5: distance test and write back
  logic [50:0] dist_s4;
  logic [47:0] thr;
  pp_pkg::part_t w_s4;
  logic dec_s4;

  assign thr     = {vis_rad_sq_r, 16'd0};
  assign dist_s4 = 51'(sqx4_r) + 51'(sqy4_r) + 51'(sqz4_r);
  always_comb begin
    w_s4 = w4_r;
    if (al4_r && (dist_s4 > 51'(thr))) begin
      w_s4.vis = 1'b1;
    end
  end
  assign dec_s4 = v4_r && ol4_r && !al4_r;

  // Spawn word from the latched item
  always_comb begin
    spawn_word.life  = spawn_life_r;
    spawn_word.pos_x = item_r.center_x;
    spawn_word.pos_y = item_r.center_y;
    spawn_word.pos_z = item_r.center_z;
    spawn_word.vel_x = pp_pkg::VEL_TAB[item_r.rand_x];
    spawn_word.vel_y = pp_pkg::VEL_TAB[item_r.rand_y];
    spawn_word.vel_z = pp_pkg::VEL_TAB[item_r.rand_z];
    spawn_word.alpha = spawn_alpha_r;
    spawn_word.vis   = 1'b0;
  end

  // Controller: next state, memory ports and result
  always_comb begin
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    iss_nxt    = iss_r;
    count_nxt  = count_r;
    sstart_nxt = sstart_r;
    res_nxt    = res_r;
    issue      = 1'b0;
    out_load   = 1'b0;
    in_w.ready = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = a4_r;
    ram_wdata  = w_s4;
    ram_raddr  = addr_r;
    sel_slot   = a1_r;
    old_alive  = 1'b0;
    spawn_now  = 1'b0;

    unique case (state_r)
      pp_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        ram_wdata = '0;
        if (addr_r == LAST_SLOT) begin
          addr_nxt  = '0;
          state_nxt = pp_pkg::ST_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      pp_pkg::ST_IDLE: begin
        in_w.ready = 1'b1;
        if (in_w.valid) begin
          res_nxt = '0;
          iss_nxt = '0;
          unique case (pp_pkg::opcode_t'(in_w.word.opcode))
            pp_pkg::OP_SPAWN: begin
              addr_nxt  = sstart_r;
              state_nxt = pp_pkg::ST_SCAN;
            end
            pp_pkg::OP_TICK: begin
              addr_nxt  = '0;
              state_nxt = pp_pkg::ST_TICK;
            end
            pp_pkg::OP_READ: begin
              res_nxt.slot = in_w.word.read_slot;
              if (13'(in_w.word.read_slot) < 13'(NUM_PARTICLES)) begin
                ram_raddr = AW'(in_w.word.read_slot);
                state_nxt = pp_pkg::ST_READ;
              end else begin
                state_nxt = pp_pkg::ST_FINISH;
              end
            end
            default: state_nxt = pp_pkg::ST_FINISH;
          endcase
        end
      end

      pp_pkg::ST_SCAN: begin
        if (iss_r != POOL_CNT) begin
          issue    = 1'b1;
          iss_nxt  = iss_r + 1'b1;
          addr_nxt = (addr_r == LAST_SLOT) ? '0 : addr_r + 1'b1;
        end
        // first dead slot found, or every slot alive: fall back to slot 0
        if (v1_r && (ram_rdata.life == 20'd0)) begin
          spawn_now = 1'b1;
        end else if (v1_r && (iss_r == POOL_CNT)) begin
          spawn_now = 1'b1;
          sel_slot  = '0;
          old_alive = 1'b1;
        end
        if (spawn_now) begin
          ram_we            = 1'b1;
          ram_waddr         = sel_slot;
          ram_wdata         = spawn_word;
          sstart_nxt        = sel_slot;
          count_nxt         = count_r + CW'(spawn_life_r != 20'd0) - CW'(old_alive);
          res_nxt.slot      = 8'(sel_slot);
          res_nxt.alive     = (spawn_life_r != 20'd0);
          res_nxt.visible   = 1'b0;
          res_nxt.pos_x     = item_r.center_x;
          res_nxt.pos_y     = item_r.center_y;
          res_nxt.pos_z     = item_r.center_z;
          res_nxt.alpha     = spawn_alpha_r;
          state_nxt         = pp_pkg::ST_FINISH;
        end
      end

      pp_pkg::ST_TICK: begin
        if (iss_r != POOL_CNT) begin
          issue    = 1'b1;
          iss_nxt  = iss_r + 1'b1;
          addr_nxt = (addr_r == LAST_SLOT) ? '0 : addr_r + 1'b1;
        end
        ram_we    = v4_r;
        count_nxt = count_r - CW'(dec_s4);
        if ((iss_r == POOL_CNT) && !v1_r && !v2_r && !v3_r && !v4_r) begin
          state_nxt = pp_pkg::ST_FINISH;
        end
      end

      pp_pkg::ST_READ: begin
        res_nxt.alive   = (ram_rdata.life != 20'd0);
        res_nxt.visible = ram_rdata.vis;
        res_nxt.pos_x   = ram_rdata.pos_x;
        res_nxt.pos_y   = ram_rdata.pos_y;
        res_nxt.pos_z   = ram_rdata.pos_z;
        res_nxt.alpha   = ram_rdata.alpha;
        state_nxt       = pp_pkg::ST_FINISH;
      end

      pp_pkg::ST_FINISH: begin
        if (!out_valid_r || out_w.ready) begin
          out_load  = 1'b1;
          state_nxt = pp_pkg::ST_IDLE;
        end
      end

      default: state_nxt = pp_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pp_pkg::ST_CLEAR;
      addr_r      <= '0;
      iss_r       <= '0;
      count_r     <= '0;
      sstart_r    <= '0;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      addr_r   <= addr_nxt;
      iss_r    <= iss_nxt;
      count_r  <= count_nxt;
      sstart_r <= sstart_nxt;
      v1_r     <= issue;
      v2_r     <= v1_r && (state_r == pp_pkg::ST_TICK);
      v3_r     <= v2_r;
      v4_r     <= v3_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_w.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result word with the live count of the finished item
  always_comb begin
    out_load_w             = res_r;
    out_load_w.alive_count = 9'(count_r);
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_w.valid && in_w.ready) begin
      item_r <= in_w.word;
      loss_r <= loss_prod[35:16];
    end
    res_r <= res_nxt;
    if (out_load) begin
      out_word_r <= out_load_w;
    end
    // tick pipeline
    a1_r    <= addr_r;
    a2_r    <= a1_r;
    w2_r    <= ram_rdata;
    life2_r <= life_s1;
    px2_r   <= px_s1;
    py2_r   <= py_s1;
    pz2_r   <= pz_s1;
    a3_r    <= a2_r;
    w3_r    <= w_s2;
    al3_r   <= alive_s2;
    ol3_r   <= (w2_r.life != 20'd0);
    dx3_r   <= {w_s2.pos_x[23], w_s2.pos_x} - {item_r.center_x[23], item_r.center_x};
    dy3_r   <= {w_s2.pos_y[23], w_s2.pos_y} - {item_r.center_y[23], item_r.center_y};
    dz3_r   <= {w_s2.pos_z[23], w_s2.pos_z} - {item_r.center_z[23], item_r.center_z};
    a4_r    <= a3_r;
    w4_r    <= w3_r;
    al4_r   <= al3_r;
    ol4_r   <= ol3_r;
    sqx4_r  <= 49'(dx3_r * dx3_r);
    sqy4_r  <= 49'(dy3_r * dy3_r);
    sqz4_r  <= 49'(dz3_r * dz3_r);
  end

  assign out_w.valid = out_valid_r;
  assign out_w.word  = out_word_r;

endmodule

// File: rtl/pp_checker.sv
// ----------------------------------------------------------------------------
// pp_checker: port-level checks of the particle pool
// Output handshake rules and the one-item-at-a-time input behaviour.
// ----------------------------------------------------------------------------
`include "particle_pool_update_defines.svh"

module pp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input pp_pkg::out_word_t out_word
);

  // a stalled result word stays offered and unchanged
  `PP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result word dropped")
  `PP_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_word), "result word changed")

  // one item in flight: no second word straight after an accepted one
  `PP_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "input taken while busy")

  // clearing pass follows reset, so no word is taken just after it
  `PP_ASSERT_RST(a_clear_pass, !rst_n |=> !in_ready, "input taken during clearing")

endmodule

bind particle_pool_update pp_checker u_pp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_w.valid),
  .in_ready  (in_w.ready),
  .out_valid (out_w.valid),
  .out_ready (out_w.ready),
  .out_word  (out_w.word)
);

// File: tb/particle_pool_update_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_pool_update_tb: self-checking bench for the particle pool
// Drives spawn, tick, read and no-op words through the input channel. A pool
// model in the bench predicts each result word, and the monitor compares the
// words field by field in order. A short directed table runs first, then
// random phases under several register settings, with idling on both sides.
// ----------------------------------------------------------------------------
module particle_pool_update_tb;

  localparam int NP        = 256;
  localparam int CLK_HALF  = 10;
  localparam int LIMIT     = 3000000;
  localparam int SETTLE    = NP + 16;
  localparam int LONG_HOLD = 1200;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pp_in_if  in_if ();
  pp_out_if out_if ();

  particle_pool_update #(.NUM_PARTICLES(NP)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_w    (in_if),
    .out_w   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Pool model: registers and per-slot stores
  longint unsigned cfg_life, cfg_alpha, cfg_fade, cfg_rad_sq;
  longint unsigned life_m [NP];
  longint          px_m [NP], py_m [NP], pz_m [NP];
  longint          vx_m [NP], vy_m [NP], vz_m [NP];
  longint unsigned alpha_m [NP];
  bit              vis_m [NP];
  int              last_slot;

  pp_pkg::out_word_t pending_q [$];
  int        errors = 0;
  int        tx_idle_pct;
  int        rx_idle_pct;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  bit        hold_req = 1'b0;
  longint    cycles = 0;
  longint    emit_x, emit_y, emit_z;

  // Directed table row
  typedef struct {
    bit                 do_cfg;
    pp_pkg::reg_idx_t   cfg_idx;
    logic [31:0]        cfg_val;
    pp_pkg::in_word_t   w;
    bit                 typed;
    pp_pkg::out_word_t  exp_w;
  } dir_row_t;

  dir_row_t dir_rows [$];

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver ready, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic cmp_field(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, e, a);
      errors++;
    end
  endtask

  // Result monitor
  always @(posedge clk) begin
    pp_pkg::out_word_t e, a;
    if (rst_n && out_if.valid && out_if.ready) begin
      a = out_if.word;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result word, got %h", $time, a);
        errors++;
      end else begin
        e = pending_q.pop_front();
        cmp_field("slot", e.slot, a.slot);
        cmp_field("alive", e.alive, a.alive);
        cmp_field("visible", e.visible, a.visible);
        cmp_field("pos_x", $signed(e.pos_x), $signed(a.pos_x));
        cmp_field("pos_y", $signed(e.pos_y), $signed(a.pos_y));
        cmp_field("pos_z", $signed(e.pos_z), $signed(a.pos_z));
        cmp_field("alpha", e.alpha, a.alpha);
        cmp_field("alive_count", e.alive_count, a.alive_count);
      end
    end
  end

  function automatic longint clamp_pos(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint vel_of(logic [6:0] r);
    return (longint'(r) * 65536 + 50) / 100 - 32768;
  endfunction

  function automatic pp_pkg::out_word_t slot_report(int s);
    pp_pkg::out_word_t r;
    r         = '0;
    r.slot    = 8'(s);
    r.alive   = (life_m[s] != 0);
    r.visible = vis_m[s];
    r.pos_x   = 24'(px_m[s]);
    r.pos_y   = 24'(py_m[s]);
    r.pos_z   = 24'(pz_m[s]);
    r.alpha   = 17'(alpha_m[s]);
    return r;
  endfunction

  // Pool model: apply one word, return its result word
  function automatic pp_pkg::out_word_t pool_step(pp_pkg::in_word_t w);
    pp_pkg::out_word_t r;
    int              s, n;
    longint          cx, cy, cz, dx, dy, dz, dt;
    longint unsigned thr, loss, dist_sum;
    r  = '0;
    cx = $signed(w.center_x);
    cy = $signed(w.center_y);
    cz = $signed(w.center_z);
    dt = longint'(w.delta_time);
    case (pp_pkg::opcode_t'(w.opcode))
      pp_pkg::OP_SPAWN: begin
        s = -1;
        for (int i = last_slot; i < NP; i++)
          if (s < 0 && life_m[i] == 0) s = i;
        for (int i = 0; i < last_slot; i++)
          if (s < 0 && life_m[i] == 0) s = i;
        if (s < 0) s = 0;
        last_slot  = s;
        px_m[s]    = cx;
        py_m[s]    = cy;
        pz_m[s]    = cz;
        vx_m[s]    = vel_of(w.rand_x);
        vy_m[s]    = vel_of(w.rand_y);
        vz_m[s]    = vel_of(w.rand_z);
        life_m[s]  = cfg_life;
        alpha_m[s] = cfg_alpha;
        vis_m[s]   = 1'b0;
        r = slot_report(s);
      end
      pp_pkg::OP_TICK: begin
        thr  = cfg_rad_sq << 16;
        loss = (cfg_fade * longint'(w.delta_time)) >> 16;
        for (int i = 0; i < NP; i++) begin
          life_m[i] = (life_m[i] > dt) ? life_m[i] - dt : 0;
          if (life_m[i] != 0) begin
            px_m[i] = clamp_pos(px_m[i] + ((vx_m[i] * dt) >>> 16));
            py_m[i] = clamp_pos(py_m[i] + ((vy_m[i] * dt) >>> 16));
            pz_m[i] = clamp_pos(pz_m[i] + ((vz_m[i] * dt) >>> 16));
            alpha_m[i] = (alpha_m[i] > loss) ? alpha_m[i] - loss : 0;
            dx = px_m[i] - cx;
            dy = py_m[i] - cy;
            dz = pz_m[i] - cz;
            dist_sum = dx * dx + dy * dy + dz * dz;
            if (dist_sum > thr) vis_m[i] = 1'b1;
          end
        end
      end
      pp_pkg::OP_READ: r = slot_report(w.read_slot);
      default: ;
    endcase
    n = 0;
    for (int i = 0; i < NP; i++)
      if (life_m[i] != 0) n++;
    r.alive_count = 9'(n);
    return r;
  endfunction

  function automatic pp_pkg::in_word_t mk_word(pp_pkg::opcode_t op, longint cx, longint cy,
                                                longint cz, int dt, int rx, int ry, int rz,
                                                int rs);
    pp_pkg::in_word_t w;
    w.opcode     = op;
    w.center_x   = 24'(cx);
    w.center_y   = 24'(cy);
    w.center_z   = 24'(cz);
    w.delta_time = 16'(dt);
    w.rand_x     = 7'(rx);
    w.rand_y     = 7'(ry);
    w.rand_z     = 7'(rz);
    w.read_slot  = 8'(rs);
    return w;
  endfunction

  function automatic pp_pkg::out_word_t empty_result(int s);
    pp_pkg::out_word_t r;
    r      = '0;
    r.slot = 8'(s);
    return r;
  endfunction

  // Send one word; the expectation is queued at the accepting edge
  task automatic send_word(pp_pkg::in_word_t w, bit typed, pp_pkg::out_word_t typed_exp);
    pp_pkg::out_word_t p;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.word  <= w;
    do @(posedge clk); while (!in_if.ready);
    p = pool_step(w);
    pending_q = {pending_q, (typed ? typed_exp : p)};
  endtask

  // Hold the input off until every result has come back
  task automatic drain;
    in_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(pp_pkg::reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      pp_pkg::REG_SPAWN_LIFE:  cfg_life   = val & 32'hFFFFF;
      pp_pkg::REG_SPAWN_ALPHA: cfg_alpha  = val & 32'h1FFFF;
      pp_pkg::REG_FADE_RATE:   cfg_fade   = val & 32'hFFFFF;
      default:                 cfg_rad_sq = val;
    endcase
  endtask

  task automatic set_all_regs(logic [31:0] l, logic [31:0] a, logic [31:0] f,
                              logic [31:0] v);
    reg_write(pp_pkg::REG_SPAWN_LIFE, l);
    reg_write(pp_pkg::REG_SPAWN_ALPHA, a);
    reg_write(pp_pkg::REG_FADE_RATE, f);
    reg_write(pp_pkg::REG_VIS_RAD_SQ, v);
  endtask

  // Centre near the phase emitter mostly, anywhere now and then
  function automatic longint pick_centre(longint base);
    if ($urandom_range(99) < 70)
      return clamp_pos(base + longint'($urandom_range(262143)) - 131072);
    return longint'($signed(24'($urandom)));
  endfunction

  function automatic pp_pkg::in_word_t random_word(int p_spawn, int p_tick, int p_read,
                                                    int dt_max);
    int               pick, rs;
    pp_pkg::opcode_t  op;
    pick = $urandom_range(99);
    if (pick < p_spawn) op = pp_pkg::OP_SPAWN;
    else if (pick < p_spawn + p_tick) op = pp_pkg::OP_TICK;
    else if (pick < p_spawn + p_tick + p_read) op = pp_pkg::OP_READ;
    else op = pp_pkg::OP_NOP;
    rs = ($urandom_range(1) == 0) ? last_slot : $urandom_range(255);
    return mk_word(op, pick_centre(emit_x), pick_centre(emit_y), pick_centre(emit_z),
                   ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(dt_max),
                   ($urandom_range(4) == 0) ? $urandom_range(127) : $urandom_range(99),
                   ($urandom_range(4) == 0) ? $urandom_range(127) : $urandom_range(99),
                   ($urandom_range(4) == 0) ? $urandom_range(127) : $urandom_range(99),
                   rs);
  endfunction

  task automatic add_row(pp_pkg::in_word_t w, bit typed, pp_pkg::out_word_t e);
    dir_row_t r;
    r.do_cfg  = 1'b0;
    r.cfg_idx = pp_pkg::REG_SPAWN_LIFE;
    r.cfg_val = '0;
    r.w       = w;
    r.typed   = typed;
    r.exp_w   = e;
    dir_rows = {dir_rows, r};
  endtask

  task automatic add_cfg_row(pp_pkg::reg_idx_t idx, logic [31:0] val, pp_pkg::in_word_t w);
    add_row(w, 1'b0, '0);
    dir_rows[$].do_cfg  = 1'b1;
    dir_rows[$].cfg_idx = idx;
    dir_rows[$].cfg_val = val;
  endtask

  initial begin
    int n_items [4];
    int t_pct [4], r_pct [4], s_pct [4], k_pct [4], d_pct [4], dtm [4];

    rst_n       = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_if.valid = 1'b0;
    in_if.word  = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;

    // Model reset state
    cfg_life   = 655360;
    cfg_alpha  = 65536;
    cfg_fade   = 163840;
    cfg_rad_sq = 262144;
    last_slot  = 0;
    for (int i = 0; i < NP; i++) begin
      life_m[i] = 0; alpha_m[i] = 0; vis_m[i] = 0;
      px_m[i] = 0; py_m[i] = 0; pz_m[i] = 0;
      vx_m[i] = 0; vy_m[i] = 0; vz_m[i] = 0;
    end

    // Directed table: reset state, field extremes, special cases
    add_row(mk_word(pp_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, empty_result(0));
    add_row(mk_word(pp_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 255), 1'b1, empty_result(255));
    add_row(mk_word(pp_pkg::OP_NOP, -8388608, 8388607, -1, 65535, 127, 127, 127, 255),
            1'b1, empty_result(0));
    add_row(mk_word(pp_pkg::OP_TICK, 0, 0, 0, 65535, 0, 0, 0, 0), 1'b1, empty_result(0));
    add_row(mk_word(pp_pkg::OP_SPAWN, 8388607, -8388608, 0, 0, 127, 0, 99, 0), 1'b0, '0);
    add_row(mk_word(pp_pkg::OP_SPAWN, -8388608, 8388607, -1, 0, 0, 127, 50, 0), 1'b0, '0);
    add_row(mk_word(pp_pkg::OP_SPAWN, 0, 0, 0, 0, 50, 50, 50, 0), 1'b0, '0);
    add_row(mk_word(pp_pkg::OP_TICK, 0, 0, 0, 1, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_word(pp_pkg::OP_TICK, 0, 0, 0, 65535, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_word(pp_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_word(pp_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0);
    add_row(mk_word(pp_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 2), 1'b0, '0);
    add_row(mk_word(pp_pkg::OP_TICK, 8388607, 8388607, 8388607, 65535, 0, 0, 0, 0),
            1'b0, '0);
    add_row(mk_word(pp_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 2), 1'b0, '0);
    // zero life: the new particle is dead at once
    add_cfg_row(pp_pkg::REG_SPAWN_LIFE, 32'd0,
                mk_word(pp_pkg::OP_SPAWN, 65536, 0, 0, 0, 99, 99, 99, 0));
    add_row(mk_word(pp_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 3), 1'b0, '0);
    add_cfg_row(pp_pkg::REG_SPAWN_LIFE, 32'hFFFFF,
                mk_word(pp_pkg::OP_SPAWN, 0, 0, 0, 0, 0, 0, 0, 0));
    add_cfg_row(pp_pkg::REG_SPAWN_ALPHA, 32'd0,
                mk_word(pp_pkg::OP_SPAWN, 0, 0, 0, 0, 99, 0, 127, 0));
    add_cfg_row(pp_pkg::REG_FADE_RATE, 32'hFFFFF,
                mk_word(pp_pkg::OP_TICK, 0, 0, 0, 65535, 0, 0, 0, 0));
    add_cfg_row(pp_pkg::REG_VIS_RAD_SQ, 32'hFFFFFFFF,
                mk_word(pp_pkg::OP_TICK, 0, 0, 0, 65535, 0, 0, 0, 0));
    add_row(mk_word(pp_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 3), 1'b0, '0);
    add_row(mk_word(pp_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 4), 1'b0, '0);

    // Reset
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (dir_rows[k]) begin
      if (dir_rows[k].do_cfg) begin
        drain();
        reg_write(dir_rows[k].cfg_idx, dir_rows[k].cfg_val);
      end
      send_word(dir_rows[k].w, dir_rows[k].typed, dir_rows[k].exp_w);
    end

    // Random phases: items, idling, operation mix, largest usual time step
    n_items = '{400, 400, 300, 400};
    t_pct   = '{17, 49, 0, 0};
    r_pct   = '{49, 17, 0, 0};
    s_pct   = '{40, 80, 40, 40};
    k_pct   = '{25, 8, 25, 25};
    d_pct   = '{30, 10, 30, 30};
    dtm     = '{65535, 4095, 8191, 65535};

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: set_all_regs(32'd655360, 32'd65536, 32'd163840, 32'd262144);
        1: set_all_regs(32'hFFFFF, 32'd65536, 32'd0, 32'd0);
        2: set_all_regs(32'd1, 32'd1, 32'hFFFFF, 32'hFFFFFFFF);
        default: set_all_regs($urandom_range(32'hFFFFF), $urandom_range(65536),
                              $urandom_range(32'hFFFFF), $urandom);
      endcase
      tx_idle_pct = t_pct[ph];
      rx_idle_pct = r_pct[ph];
      emit_x = longint'($signed(24'($urandom)));
      emit_y = longint'($signed(24'($urandom)));
      emit_z = longint'($signed(24'($urandom)));
      // long receiver hold-off so that the block backs up
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < n_items[ph]; n++) begin
        // a full pause mid-phase until everything is back
        if (ph == 0 && n == n_items[ph] / 2) drain();
        send_word(random_word(s_pct[ph], k_pct[ph], d_pct[ph], dtm[ph]), 1'b0, '0);
      end
    end

    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: particle_pool_update.f
+incdir+rtl
rtl/pp_pkg.sv
rtl/pp_intf.sv
rtl/pp_ram.sv
rtl/particle_pool_update.sv
rtl/pp_checker.sv
tb/particle_pool_update_tb.sv
